/* rtl/mcr_pkg.sv */
// Package: shared types and constants for the mass and CFL reduction unit.
package mcr_pkg;
    localparam int unsigned CFL_W   = 24;
    localparam int unsigned MASS_W  = 64;
    localparam logic [CFL_W-1:0] CFL_MAX = {CFL_W{1'b1}};
    localparam logic [23:0] TIME_STEP_RESET = 24'd65536;

    typedef struct packed {
        logic [31:0] density;
        logic [31:0] cell_area;
        logic [23:0] layer_thickness;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [23:0] vel_z;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [63:0] total_mass;
        logic [23:0] max_cfl_horizontal;
        logic [23:0] max_cfl_vertical;
    } t_out_item;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [31:0] density;
        logic [31:0] cell_area;
        logic [23:0] layer_thickness;
        logic [23:0] mag_x;
        logic [23:0] mag_z;
        logic [23:0] mag_y;
        logic        area_zero;
        logic        thick_zero;
        logic        last_item;
    } t_work;

    function automatic logic [23:0] magnitude24(input logic [23:0] v);
        logic [23:0] r;
        r = v[23] ? (24'd0 - v) : v;
        return r;
    endfunction
endpackage

/* rtl/mcr_if.sv */
// Interfaces: valid/ready channels for input items, results and configuration.
interface mcr_in_if;
    logic              valid;
    logic              ready;
    mcr_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcr_out_if;
    logic               valid;
    logic               ready;
    mcr_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mass_and_cfl_reduction_unit.sv */
// Flow: an accepted item is registered in the queue, then the back end works it through the
// mass multiplies, the bit-serial 128-step horizontal divide,
// 24-step square root and 104-step vertical divide on one shared sequencer.
// The back end works one item at a time and holds a last item while a result waits at the output;
// a two-entry queue lets the front accept while the back works.
// Reset (i_rst_n low, synchronous): clears sums, peaks, queue; time_step = 1.0.
module mass_and_cfl_reduction_unit #(
    parameter int unsigned QDEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcr_in_if.sink    in_ch,
    mcr_out_if.source out_ch,
    mcr_cfg_if.sink   cfg_ch
);
    logic [23:0]     r_time_step;
    logic            work_valid, work_ready;
    mcr_pkg::t_work  work;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= mcr_pkg::TIME_STEP_RESET;
        end else if (cfg_ch.valid) begin
            r_time_step <= cfg_ch.data;
        end
    end

    mcr_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_work_valid(work_valid), .o_work(work), .i_work_ready(work_ready)
    );

    mcr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_time_step(r_time_step),
        .i_work_valid(work_valid), .i_work(work), .o_work_ready(work_ready),
        .out_ch(out_ch)
    );
endmodule

/* rtl/mcr_front.sv */
// Front end: accepts items, takes magnitudes, flags zero divisors, queues work.
module mcr_front #(
    parameter int unsigned QDEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcr_in_if.sink           in_ch,
    output logic             o_work_valid,
    output mcr_pkg::t_work   o_work,
    input  logic             i_work_ready
);
    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CW = $clog2(QDEPTH + 1);

    mcr_pkg::t_work r_q [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    mcr_pkg::t_work n_w;
    logic push, pop;

    assign in_ch.ready  = (r_cnt != CW'(QDEPTH));
    assign push         = in_ch.valid && in_ch.ready;
    assign o_work_valid = (r_cnt != '0);
    assign pop          = o_work_valid && i_work_ready;
    assign o_work       = r_q[r_rp];

    always_comb begin
        n_w.density         = in_ch.data.density;
        n_w.cell_area       = in_ch.data.cell_area;
        n_w.layer_thickness = in_ch.data.layer_thickness;
        n_w.mag_x           = mcr_pkg::magnitude24(in_ch.data.vel_x);
        n_w.mag_y           = mcr_pkg::magnitude24(in_ch.data.vel_y);
        n_w.mag_z           = mcr_pkg::magnitude24(in_ch.data.vel_z);
        n_w.area_zero       = (in_ch.data.cell_area == '0);
        n_w.thick_zero      = (in_ch.data.layer_thickness == '0);
        n_w.last_item       = in_ch.data.last_item;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'(QDEPTH) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !pop) else $error("queue underflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count slip");
`endif
endmodule

/* rtl/mcr_back.sv */
// Back end: sequenced mass term, shared divider, square root and reduction.
module mcr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [23:0]      i_time_step,
    input  logic             i_work_valid,
    input  mcr_pkg::t_work   i_work,
    output logic             o_work_ready,
    mcr_out_if.source        out_ch
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_MUL3  = 9'b000001000,
        S_HDIV  = 9'b000010000,
        S_SQRT  = 9'b000100000,
        S_VDIV  = 9'b001000000,
        S_FOLD  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state;
    mcr_pkg::t_work r_w;
    logic [63:0]  r_p;      // scratch product
    logic [63:0]  r_p2;
    logic [63:0]  r_term;
    logic [127:0] r_num;
    logic [64:0]  r_rem;
    logic [64:0]  r_div;
    logic [48:0]  r_quo;
    logic [6:0]   r_cnt;
    logic [1:0]   r_sub;
    logic [48:0]  r_sx;
    logic [48:0]  r_sres;
    logic [48:0]  r_sbit;
    logic [23:0]  r_ch;
    logic [23:0]  r_cv;
    logic [63:0]  r_mass;
    logic [23:0]  r_pk_h;
    logic [23:0]  r_pk_v;
    logic [63:0]  r_dd;
    logic [47:0]  r_s;

    logic [64:0] rem_sh;
    logic        ge;
    logic [64:0] mass_add;
    logic [48:0] s_trial;

    assign o_work_ready = (r_state == S_IDLE);
    assign rem_sh  = {r_rem[63:0], r_num[127]};
    assign ge      = rem_sh >= r_div;
    assign s_trial = r_sres + r_sbit;
    assign mass_add = {1'b0, r_mass} + {1'b0, r_term};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mass    <= '0;
            r_pk_h    <= '0;
            r_pk_v    <= '0;
            out_ch.valid <= 1'b0;
        end else begin
            // a result leaving in the same cycle as a new one is loaded stays valid
            if (out_ch.valid && out_ch.ready && !(r_state == S_EMIT && r_w.last_item)) begin
                out_ch.valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_work_valid) begin
                        r_w     <= i_work;
                        r_sub   <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    // one multiply per cycle
                    case (r_sub)
                        2'd0: r_p  <= 64'(r_w.density) * 64'(r_w.cell_area);
                        2'd1: r_dd <= 64'(i_time_step) * 64'(i_time_step);
                        2'd2: r_p2 <= 64'(r_w.mag_x) * 64'(r_w.mag_x);
                        default: r_s <= 48'(r_p2) + 48'(64'(r_w.mag_y) * 64'(r_w.mag_y));
                    endcase
                    r_sub <= r_sub + 1'b1;
                    if (r_sub == 2'd3) begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_term <= 64'(r_p[63:32]) * 64'(r_w.layer_thickness);
                    r_p2   <= 64'(r_p[31:0]) * 64'(r_w.layer_thickness);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_term <= r_term + 64'(r_p2[63:32]);
                    // D*D*S: four 24 x 24 partials, cross terms summed next cycle
                    r_num  <= {32'd0, 48'(r_dd[47:24]) * 48'(r_s[47:24]),
                               48'(r_dd[23:0]) * 48'(r_s[23:0])};
                    r_p    <= 64'(r_dd[47:24]) * 64'(r_s[23:0]);
                    r_p2   <= 64'(r_dd[23:0]) * 64'(r_s[47:24]);
                    r_state <= S_HDIV;
                    r_cnt  <= '0;
                    r_sub  <= '0;
                end
                S_HDIV: begin
                    if (r_sub == 2'd0) begin
                        r_num <= r_num + (128'(r_p) << 24) + (128'(r_p2) << 24);
                        r_div <= 65'(r_w.cell_area) << 17;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_sub <= 2'd1;
                    end else begin
                        r_rem <= ge ? rem_sh - r_div : rem_sh;
                        r_num <= r_num << 1;
                        if (r_quo[48]) begin
                            r_quo <= r_quo;
                        end else begin
                            r_quo <= {r_quo[47:0], ge};
                        end
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 7'd127) begin
                            r_state <= S_SQRT;
                            r_sub   <= '0;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_sub == 2'd0) begin
                        r_sx   <= r_quo;
                        r_sres <= '0;
                        r_sbit <= 49'(1) << 46;
                        r_sub  <= 2'd1;
                    end else if (r_sbit == '0) begin
                        if (r_w.area_zero || r_quo[48]) begin
                            r_ch <= mcr_pkg::CFL_MAX;
                        end else begin
                            r_ch <= r_sres[23:0];
                        end
                        r_num   <= {40'd0, 64'(i_time_step) * 64'(r_w.mag_z), 24'd0};
                        r_div   <= 65'(r_w.layer_thickness);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_VDIV;
                    end else begin
                        if (r_sx >= s_trial) begin
                            r_sx   <= r_sx - s_trial;
                            r_sres <= (r_sres >> 1) + r_sbit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end
                S_VDIV: begin
                    // 48-bit dividend sits in r_num[71:24]; 104 steps consume r_num[127:24]
                    r_rem <= ge ? rem_sh - r_div : rem_sh;
                    r_num <= r_num << 1;
                    if (!r_quo[48]) begin
                        r_quo <= {r_quo[47:0], ge};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd103) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_cv <= (r_w.thick_zero || (r_quo[48:24] != '0)) ?
                            mcr_pkg::CFL_MAX : r_quo[23:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!out_ch.valid || out_ch.ready || !r_w.last_item) begin
                        if (r_w.last_item) begin
                            out_ch.valid <= 1'b1;
                            out_ch.data.total_mass <= mass_add[64] ? '1 : mass_add[63:0];
                            out_ch.data.max_cfl_horizontal <= (r_ch > r_pk_h) ? r_ch : r_pk_h;
                            out_ch.data.max_cfl_vertical   <= (r_cv > r_pk_v) ? r_cv : r_pk_v;
                            r_mass <= '0;
                            r_pk_h <= '0;
                            r_pk_v <= '0;
                        end else begin
                            r_mass <= mass_add[64] ? '1 : mass_add[63:0];
                            if (r_ch > r_pk_h) r_pk_h <= r_ch;
                            if (r_cv > r_pk_v) r_pk_v <= r_cv;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_work_ready && i_work_valid |=> r_state == S_MUL1) else $error("bad start");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
        else $error("result changed while stalled");
`endif
endmodule
